[rtl/hcbd_pkg.sv]
// Package for the chunked body decoder: widths, byte codes and hex helper.
package hcbd_pkg;

  localparam int DATA_W       = 8;
  localparam int FIELD_W      = 32;
  localparam int SIZE_BITS_DEF = 32;
  localparam int HEX_W        = 4;

  localparam logic [DATA_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [DATA_W-1:0] BYTE_LF = 8'h0A;

  typedef struct packed {
    logic              is_hex;
    logic [HEX_W-1:0]  value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [DATA_W-1:0] c);
    hex_digit_t r;
    r.is_hex = 1'b0;
    r.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.value  = HEX_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.is_hex = 1'b1;
      r.value  = HEX_W'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex = 1'b1;
      r.value  = HEX_W'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

[rtl/hcbd_if.sv]
// Stream interfaces for the chunked body decoder: raw byte in, decoded beat out.
interface hcbd_in_if;
  import hcbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              begin_req;

  modport source (output valid, data_byte, begin_req, input ready);
  modport sink   (input valid, data_byte, begin_req, output ready);
endinterface

interface hcbd_out_if;
  import hcbd_pkg::*;
  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [DATA_W-1:0]  payload_byte;
  logic [FIELD_W-1:0] chunk_offset;
  logic [FIELD_W-1:0] chunk_length;
  logic               last_of_chunk;
  logic               done_res;
  logic               size_overflow;

  modport source (output valid, payload_valid, payload_byte, chunk_offset, chunk_length,
                  last_of_chunk, done_res, size_overflow, input ready);
  modport sink   (input valid, payload_valid, payload_byte, chunk_offset, chunk_length,
                  last_of_chunk, done_res, size_overflow, output ready);
endinterface

[rtl/http_chunked_body_decoder.sv]
// HTTP/1.1 chunked body decoder: one raw byte in, one decoded beat out.
//
// in_ch carries one raw byte of the chunked stream per beat, with begin_req
// restarting the parser before that byte. out_ch returns exactly one beat per
// input beat: payload flag, byte, offset within the chunk, declared chunk
// length, last-of-chunk, done and the sticky size overflow flag.
//
// The parser state and the result register update at the edge that accepts
// the byte. Throughput is one byte per cycle; the single result register is
// the only storage between the channels, and in_ch.ready is high whenever
// that register is empty or being drained in the same cycle.
//
// Reset clears the parser to expect a size line, zeroes size, offset and the
// overflow flag, and empties the result register. When the receiver stalls,
// the pending beat holds and in_ch.ready drops until it is taken.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hcbd_in_if.sink       in_ch,
  hcbd_out_if.source    out_ch
);
  import hcbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE, PH_EXT, PH_LF, PH_BODY, PH_DCR, PH_DLF, PH_FINAL
  } phase_t;

  localparam int EXT_W = 64;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [SIZE_BITS-1:0] off_r, off_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_valid_r;
  logic                 pv_r, pv_nxt;
  logic [DATA_W-1:0]    pb_r, pb_nxt;
  logic [FIELD_W-1:0]   coff_r, coff_nxt;
  logic [FIELD_W-1:0]   clen_r, clen_nxt;
  logic                 last_r, last_nxt;
  logic                 done_r, done_nxt;

  phase_t               phase_cur;
  logic [SIZE_BITS-1:0] acc_cur, off_cur, off_inc;
  logic                 ovf_cur;
  hex_digit_t           hd;
  logic                 accept;
  logic [EXT_W-1:0]     off_ext, acc_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_cur = in_ch.begin_req ? PH_SIZE : phase_r;
    acc_cur   = in_ch.begin_req ? '0 : acc_r;
    off_cur   = in_ch.begin_req ? '0 : off_r;
    ovf_cur   = in_ch.begin_req ? 1'b0 : ovf_r;
    hd        = hex_decode(in_ch.data_byte);
    off_inc   = off_cur + SIZE_BITS'(1);
    off_ext   = EXT_W'(off_cur);
    acc_ext   = EXT_W'(acc_cur);

    phase_nxt = phase_cur;
    acc_nxt   = acc_cur;
    off_nxt   = off_cur;
    ovf_nxt   = ovf_cur;
    pv_nxt    = 1'b0;
    pb_nxt    = '0;
    coff_nxt  = '0;
    clen_nxt  = '0;
    last_nxt  = 1'b0;
    done_nxt  = 1'b0;

    case (phase_cur)
      PH_SIZE: begin
        if (hd.is_hex) begin
          if (|acc_cur[SIZE_BITS-1 -: HEX_W]) begin
            acc_nxt = '1;
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = {acc_cur[SIZE_BITS-HEX_W-1:0], hd.value};
          end
        end else if (in_ch.data_byte == BYTE_CR) begin
          phase_nxt = PH_LF;
        end else begin
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        if (in_ch.data_byte == BYTE_CR) phase_nxt = PH_LF;
      end
      PH_LF: begin
        if (in_ch.data_byte == BYTE_LF) begin
          if (acc_cur != '0) begin
            phase_nxt = PH_BODY;
            off_nxt   = '0;
          end else begin
            phase_nxt = PH_FINAL;
            done_nxt  = 1'b1;
          end
        end
      end
      PH_BODY: begin
        pv_nxt   = 1'b1;
        pb_nxt   = in_ch.data_byte;
        coff_nxt = off_ext[FIELD_W-1:0];
        clen_nxt = acc_ext[FIELD_W-1:0];
        off_nxt  = off_inc;
        if (off_inc == acc_cur) begin
          last_nxt  = 1'b1;
          phase_nxt = PH_DCR;
        end
      end
      PH_DCR: begin
        if (in_ch.data_byte == BYTE_CR) phase_nxt = PH_DLF;
      end
      PH_DLF: begin
        if (in_ch.data_byte == BYTE_LF) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
        end
      end
      PH_FINAL: begin
        done_nxt = 1'b1;
      end
      default: begin
        phase_nxt = PH_SIZE;
        acc_nxt   = '0;
        off_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      acc_r       <= '0;
      off_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      pb_r        <= '0;
      coff_r      <= '0;
      clen_r      <= '0;
      last_r      <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        off_r   <= off_nxt;
        ovf_r   <= ovf_nxt;
        pv_r    <= pv_nxt;
        pb_r    <= pb_nxt;
        coff_r  <= coff_nxt;
        clen_r  <= clen_nxt;
        last_r  <= last_nxt;
        done_r  <= done_nxt;
      end
      if (in_ch.ready) out_valid_r <= accept;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_valid = pv_r;
  assign out_ch.payload_byte  = pb_r;
  assign out_ch.chunk_offset  = coff_r;
  assign out_ch.chunk_length  = clen_r;
  assign out_ch.last_of_chunk = last_r;
  assign out_ch.done_res      = done_r;
  assign out_ch.size_overflow = ovf_r;

  // in body the offset stays below a nonzero declared size
  a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (acc_r != '0 && off_r < acc_r))
    else $error("body offset out of range");

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> pv_r)
    else $error("last_of_chunk without payload");

  a_done_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> !pv_r)
    else $error("payload beat after done");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ovf_r && ovf_nxt && !in_ch.begin_req) |=> (acc_r == '1))
    else $error("overflow without saturated size");

endmodule
